// ===== hdl/bce_pkg.sv =====
package bce_pkg;

   localparam int FLT_W     = 32;
   localparam int RAM_DEPTH = 32;
   localparam int RAM_AW    = 5;
   localparam int PC_W      = 6;
   localparam int CVT_W     = 25;
   localparam int SCALE_W   = 8;

   // sequencer operations; the first four are also the float unit's operations
   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_SUB   = 3'd1;
   localparam logic [2:0] OP_MUL   = 3'd2;
   localparam logic [2:0] OP_CVT   = 3'd3;
   localparam logic [2:0] OP_TST_T = 3'd4;
   localparam logic [2:0] OP_TST_P = 3'd5;
   localparam logic [2:0] OP_DONE  = 3'd6;

   // operand sources
   localparam logic [2:0] S_RAM   = 3'd0;
   localparam logic [2:0] S_TPREV = 3'd1;
   localparam logic [2:0] S_TOLD  = 3'd2;
   localparam logic [2:0] S_PPREV = 3'd3;
   localparam logic [2:0] S_POLD  = 3'd4;

   // integer kinds for conversion
   localparam logic [2:0] CK_U16  = 3'd0;
   localparam logic [2:0] CK_S16  = 3'd1;
   localparam logic [2:0] CK_S16B = 3'd2;
   localparam logic [2:0] CK_S8   = 3'd3;
   localparam logic [2:0] CK_TRAW = 3'd4;
   localparam logic [2:0] CK_PRAW = 3'd5;

   // scratch slots
   localparam int R_K0   = 0;
   localparam int R_K1   = 1;
   localparam int R_K2   = 2;
   localparam int R_K3   = 3;
   localparam int R_K4   = 4;
   localparam int R_K5   = 5;
   localparam int R_K6   = 6;
   localparam int R_K7   = 7;
   localparam int R_K8   = 8;
   localparam int R_K9   = 9;
   localparam int R_K10  = 10;
   localparam int R_K11  = 11;
   localparam int R_K12  = 12;
   localparam int R_K13  = 13;
   localparam int R_TRAW = 14;
   localparam int R_PRAW = 15;
   localparam int R_D1   = 16;
   localparam int R_D2   = 17;
   localparam int R_D3   = 18;
   localparam int R_D4   = 19;
   localparam int R_T    = 20;
   localparam int R_TT   = 21;
   localparam int R_TTT  = 22;
   localparam int R_O1   = 23;
   localparam int R_O2   = 24;
   localparam int R_P    = 25;
   localparam int R_DPOS = 26;
   localparam int R_DNEG = 27;

   typedef struct packed {
      logic [2:0]                op;
      logic [RAM_AW-1:0]         dst;
      logic [2:0]                a_src;
      logic [RAM_AW-1:0]         a_addr;
      logic [2:0]                b_src;
      logic [RAM_AW-1:0]         b_addr;
      logic [2:0]                cvt_kind;
      logic signed [SCALE_W-1:0] scale;
   } prog_type;

   typedef struct packed {
      logic [2:0]                op;
      logic [FLT_W-1:0]          a;
      logic [FLT_W-1:0]          b;
      logic signed [CVT_W-1:0]   cvt_int;
      logic signed [SCALE_W-1:0] scale;
   } fpu_req_type;

   function automatic prog_type arith(input logic [2:0] op, input int dst,
                                      input logic [2:0] asrc, input int aaddr,
                                      input logic [2:0] bsrc, input int baddr);
      prog_type e;
      e          = '0;
      e.op       = op;
      e.dst      = RAM_AW'(dst);
      e.a_src    = asrc;
      e.a_addr   = RAM_AW'(aaddr);
      e.b_src    = bsrc;
      e.b_addr   = RAM_AW'(baddr);
      return e;
   endfunction

   // byte index travels in a_addr
   function automatic prog_type cvt(input int dst, input logic [2:0] kind,
                                    input int byte_idx, input int scale);
      prog_type e;
      e          = '0;
      e.op       = OP_CVT;
      e.dst      = RAM_AW'(dst);
      e.a_addr   = RAM_AW'(byte_idx);
      e.cvt_kind = kind;
      e.scale    = SCALE_W'(scale);
      return e;
   endfunction

   function automatic prog_type ctl(input logic [2:0] op);
      prog_type e;
      e    = '0;
      e.op = op;
      return e;
   endfunction

   function automatic prog_type prog_entry(input logic [PC_W-1:0] pc);
      prog_type e;
      unique case (pc)
         6'd0:  e = cvt(R_K0,   CK_U16,  0,   8);
         6'd1:  e = cvt(R_K1,   CK_U16,  2, -30);
         6'd2:  e = cvt(R_K2,   CK_S8,   4, -48);
         6'd3:  e = cvt(R_K3,   CK_S16B, 5, -20);
         6'd4:  e = cvt(R_K4,   CK_S16B, 7, -29);
         6'd5:  e = cvt(R_K5,   CK_S8,   9, -32);
         6'd6:  e = cvt(R_K6,   CK_S8,  10, -37);
         6'd7:  e = cvt(R_K7,   CK_U16, 11,   3);
         6'd8:  e = cvt(R_K8,   CK_U16, 13,  -6);
         6'd9:  e = cvt(R_K9,   CK_S8,  15,  -8);
         6'd10: e = cvt(R_K10,  CK_S8,  16, -15);
         6'd11: e = cvt(R_K11,  CK_S16, 17, -48);
         6'd12: e = cvt(R_K12,  CK_S8,  19, -48);
         6'd13: e = cvt(R_K13,  CK_S8,  20, -65);
         6'd14: e = cvt(R_TRAW, CK_TRAW, 0,   0);
         6'd15: e = cvt(R_PRAW, CK_PRAW, 0,   0);
         // temperature
         6'd16: e = arith(OP_SUB, R_D1, S_RAM, R_TRAW, S_RAM, R_K0);
         6'd17: e = arith(OP_MUL, R_D2, S_RAM, R_D1,   S_RAM, R_K1);
         6'd18: e = arith(OP_MUL, R_D3, S_RAM, R_D1,   S_RAM, R_D1);
         6'd19: e = arith(OP_MUL, R_D3, S_RAM, R_D3,   S_RAM, R_K2);
         6'd20: e = arith(OP_ADD, R_T,  S_RAM, R_D2,   S_RAM, R_D3);
         6'd21: e = ctl(OP_TST_T);
         6'd22: e = arith(OP_ADD, R_T,  S_TPREV, 0,    S_TPREV, 0);
         6'd23: e = arith(OP_SUB, R_T,  S_RAM, R_T,    S_TOLD, 0);
         // pressure
         6'd24: e = arith(OP_MUL, R_TT,  S_RAM, R_T,   S_RAM, R_T);
         6'd25: e = arith(OP_MUL, R_TTT, S_RAM, R_TT,  S_RAM, R_T);
         6'd26: e = arith(OP_MUL, R_D1,  S_RAM, R_K8,  S_RAM, R_T);
         6'd27: e = arith(OP_MUL, R_D2,  S_RAM, R_K9,  S_RAM, R_TT);
         6'd28: e = arith(OP_MUL, R_D3,  S_RAM, R_K10, S_RAM, R_TTT);
         6'd29: e = arith(OP_ADD, R_O1,  S_RAM, R_K7,  S_RAM, R_D1);
         6'd30: e = arith(OP_ADD, R_O1,  S_RAM, R_O1,  S_RAM, R_D2);
         6'd31: e = arith(OP_ADD, R_O1,  S_RAM, R_O1,  S_RAM, R_D3);
         6'd32: e = arith(OP_MUL, R_D1,  S_RAM, R_K4,  S_RAM, R_T);
         6'd33: e = arith(OP_MUL, R_D2,  S_RAM, R_K5,  S_RAM, R_TT);
         6'd34: e = arith(OP_MUL, R_D3,  S_RAM, R_K6,  S_RAM, R_TTT);
         6'd35: e = arith(OP_ADD, R_O2,  S_RAM, R_K3,  S_RAM, R_D1);
         6'd36: e = arith(OP_ADD, R_O2,  S_RAM, R_O2,  S_RAM, R_D2);
         6'd37: e = arith(OP_ADD, R_O2,  S_RAM, R_O2,  S_RAM, R_D3);
         6'd38: e = arith(OP_MUL, R_O2,  S_RAM, R_PRAW, S_RAM, R_O2);
         6'd39: e = arith(OP_MUL, R_D1,  S_RAM, R_PRAW, S_RAM, R_PRAW);
         6'd40: e = arith(OP_MUL, R_D2,  S_RAM, R_K12, S_RAM, R_T);
         6'd41: e = arith(OP_ADD, R_D2,  S_RAM, R_K11, S_RAM, R_D2);
         6'd42: e = arith(OP_MUL, R_D3,  S_RAM, R_D1,  S_RAM, R_D2);
         6'd43: e = arith(OP_MUL, R_D4,  S_RAM, R_D1,  S_RAM, R_PRAW);
         6'd44: e = arith(OP_MUL, R_D4,  S_RAM, R_D4,  S_RAM, R_K13);
         6'd45: e = arith(OP_ADD, R_D4,  S_RAM, R_D3,  S_RAM, R_D4);
         6'd46: e = arith(OP_ADD, R_P,   S_RAM, R_O1,  S_RAM, R_O2);
         6'd47: e = arith(OP_ADD, R_P,   S_RAM, R_P,   S_RAM, R_D4);
         6'd48: e = arith(OP_SUB, R_DPOS, S_RAM, R_P,  S_PPREV, 0);
         6'd49: e = arith(OP_SUB, R_DNEG, S_PPREV, 0,  S_RAM, R_P);
         6'd50: e = ctl(OP_TST_P);
         6'd51: e = arith(OP_ADD, R_P,  S_PPREV, 0,    S_PPREV, 0);
         6'd52: e = arith(OP_SUB, R_P,  S_RAM, R_P,    S_POLD, 0);
         default: e = ctl(OP_DONE);
      endcase
      return e;
   endfunction

endpackage

// ===== hdl/barometric_compensation_engine.sv =====
// channel   direction  contents (low bits first)
// req_*     in         tdata: raw_temperature[23:0], raw_pressure[47:24]
// rsp_*     out        tdata: pressure_out[31:0], temperature_out[63:32];
//                      tuser: temp_replaced[0], press_replaced[1]
// csr_*     in/out     8 registers at byte address 8*index, 64-bit data
//
// one transfer in runs 16 conversions and 31 to 35 float operations, each through the
// shared float unit in steps (scratch read, three unit stages, write back), plus a
// step per range test and one to load the result; the replacement steps set the spread
// req_tready is high only between items; the next item can be taken in the cycle after
// the result is loaded into the output register
// a result waiting on rsp_tready holds the sequencer at its last step
// reset clears registers, history and control; the scratch memory needs no clearing
module barometric_compensation_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // raw_temperature, raw_pressure
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // pressure_out, temperature_out
   output logic [1:0]  rsp_tuser,   // temp_replaced, press_replaced
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   import bce_pkg::*;

   localparam logic [2:0] REG_CAL_LO = 3'd0;
   localparam logic [2:0] REG_CAL_MID = 3'd1;
   localparam logic [2:0] REG_CAL_HI = 3'd2;
   localparam logic [2:0] REG_TFLOOR = 3'd3;
   localparam logic [2:0] REG_TCEIL = 3'd4;
   localparam logic [2:0] REG_PFLOOR = 3'd5;
   localparam logic [2:0] REG_PCEIL = 3'd6;
   localparam logic [2:0] REG_PSTEP = 3'd7;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   localparam logic [2:0] PH_LAST = 3'd4;

   function automatic logic flt_is_nan(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] != '0);
   endfunction

   function automatic logic [31:0] flt_key(input logic [31:0] x);
      return x[31] ? ~x : (x | 32'h8000_0000);
   endfunction

   function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
      logic both_zero;
      both_zero = ((a[30:0] | b[30:0]) == '0);
      return !flt_is_nan(a) && !flt_is_nan(b) && !both_zero && (flt_key(a) < flt_key(b));
   endfunction

   function automatic logic flt_nz(input logic [31:0] x);
      return x[30:0] != '0;
   endfunction

   // configuration
   logic [63:0] cal_lo_ff, cal_mid_ff;
   logic [39:0] cal_hi_ff;
   logic [31:0] tfloor_ff, tceil_ff, pfloor_ff, pceil_ff, pstep_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_lo_ff  <= '0;
         cal_mid_ff <= '0;
         cal_hi_ff  <= '0;
         tfloor_ff  <= '0;
         tceil_ff   <= '0;
         pfloor_ff  <= '0;
         pceil_ff   <= '0;
         pstep_ff   <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_CAL_LO:  cal_lo_ff  <= csr_pwdata;
            REG_CAL_MID: cal_mid_ff <= csr_pwdata;
            REG_CAL_HI:  cal_hi_ff  <= csr_pwdata[39:0];
            REG_TFLOOR:  tfloor_ff  <= csr_pwdata[31:0];
            REG_TCEIL:   tceil_ff   <= csr_pwdata[31:0];
            REG_PFLOOR:  pfloor_ff  <= csr_pwdata[31:0];
            REG_PCEIL:   pceil_ff   <= csr_pwdata[31:0];
            REG_PSTEP:   pstep_ff   <= csr_pwdata[31:0];
            default:     cal_lo_ff  <= cal_lo_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_CAL_LO:  csr_prdata = cal_lo_ff;
         REG_CAL_MID: csr_prdata = cal_mid_ff;
         REG_CAL_HI:  csr_prdata = {24'd0, cal_hi_ff};
         REG_TFLOOR:  csr_prdata = {32'd0, tfloor_ff};
         REG_TCEIL:   csr_prdata = {32'd0, tceil_ff};
         REG_PFLOOR:  csr_prdata = {32'd0, pfloor_ff};
         REG_PCEIL:   csr_prdata = {32'd0, pceil_ff};
         REG_PSTEP:   csr_prdata = {32'd0, pstep_ff};
         default:     csr_prdata = '0;
      endcase
   end

   // sequencer
   logic             state_ff, state_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [2:0]       ph_ff, ph_in;
   logic [23:0]      traw_ff, praw_ff;
   logic [31:0]      th0_ff, th1_ff, ph0_ff, ph1_ff;
   logic [31:0]      t_ff, p_ff, dpos_ff, dneg_ff;
   logic             trep_ff, trep_in, prep_ff, prep_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rsp_data_ff;
   logic [1:0]       rsp_user_ff;
   prog_type         cur;
   logic             is_arith, wr_en, done_go, t_cond, p_cond;
   logic [31:0]      rdata_a, rdata_b, fpu_res;
   fpu_req_type      fpu_req;
   logic [167:0]     cal_all;
   logic [7:0]       byte0, byte1;

   assign cur        = prog_entry(pc_ff);
   assign is_arith   = (cur.op == OP_ADD) || (cur.op == OP_SUB) ||
                       (cur.op == OP_MUL) || (cur.op == OP_CVT);
   assign wr_en      = (state_ff == ST_RUN) && is_arith && (ph_ff == PH_LAST);
   assign done_go    = (state_ff == ST_RUN) && (cur.op == OP_DONE) &&
                       (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   bce_ram #(
      .WIDTH (FLT_W),
      .DEPTH (RAM_DEPTH)
   ) u_scratch (
      .clock   (clock),
      .we      (wr_en),
      .waddr   (cur.dst),
      .wdata   (fpu_res),
      .raddr_a (cur.a_addr),
      .rdata_a (rdata_a),
      .raddr_b (cur.b_addr),
      .rdata_b (rdata_b)
   );

   function automatic logic [31:0] pick(input logic [2:0] src, input logic [31:0] ram,
                                        input logic [31:0] tp, input logic [31:0] to,
                                        input logic [31:0] pp, input logic [31:0] po);
      logic [31:0] v;
      unique case (src)
         S_RAM:   v = ram;
         S_TPREV: v = tp;
         S_TOLD:  v = to;
         S_PPREV: v = pp;
         S_POLD:  v = po;
         default: v = ram;
      endcase
      return v;
   endfunction

   // calibration field pick; byte index comes from a_addr
   assign cal_all = {cal_hi_ff, cal_mid_ff, cal_lo_ff};
   assign byte0   = cal_all[8*cur.a_addr +: 8];
   assign byte1   = cal_all[8*(cur.a_addr + 5'd1) +: 8];

   always_comb begin
      fpu_req.op    = cur.op;
      fpu_req.a     = pick(cur.a_src, rdata_a, th0_ff, th1_ff, ph0_ff, ph1_ff);
      fpu_req.b     = pick(cur.b_src, rdata_b, th0_ff, th1_ff, ph0_ff, ph1_ff);
      fpu_req.scale = cur.scale;
      unique case (cur.cvt_kind)
         CK_U16:  fpu_req.cvt_int = {9'd0, byte1, byte0};
         CK_S16:  fpu_req.cvt_int = 25'(signed'({byte1, byte0}));
         CK_S16B: fpu_req.cvt_int = 25'(signed'({byte1, byte0})) - 25'sd16384;
         CK_S8:   fpu_req.cvt_int = 25'(signed'(byte0));
         CK_TRAW: fpu_req.cvt_int = {1'b0, traw_ff};
         CK_PRAW: fpu_req.cvt_int = {1'b0, praw_ff};
         default: fpu_req.cvt_int = '0;
      endcase
   end

   bce_fpu u_fpu (
      .clock  (clock),
      .req    (fpu_req),
      .result (fpu_res)
   );

   // temperature uses the value before the history shift: prev is place 0, older place 1
   assign t_cond = flt_lt(t_ff, tfloor_ff) || (flt_lt(tceil_ff, t_ff) && flt_nz(th1_ff));
   assign p_cond = flt_lt(p_ff, pfloor_ff) || flt_lt(pceil_ff, p_ff) ||
                   (flt_lt(pstep_ff, dpos_ff) && flt_nz(ph1_ff)) ||
                   (flt_lt(pstep_ff, dneg_ff) && flt_nz(ph1_ff));

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      ph_in        = ph_ff;
      trep_in      = trep_ff;
      prep_in      = prep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_RUN;
               pc_in    = '0;
               ph_in    = '0;
               trep_in  = 1'b0;
               prep_in  = 1'b0;
            end
         end
         ST_RUN: begin
            priority if (is_arith) begin
               if (ph_ff == PH_LAST) begin
                  ph_in = '0;
                  pc_in = pc_ff + 1'b1;
               end else begin
                  ph_in = ph_ff + 1'b1;
               end
            end else if (cur.op == OP_TST_T) begin
               trep_in = t_cond;
               pc_in   = t_cond ? pc_ff + PC_W'(1) : pc_ff + PC_W'(3);
            end else if (cur.op == OP_TST_P) begin
               prep_in = p_cond;
               pc_in   = p_cond ? pc_ff + PC_W'(1) : pc_ff + PC_W'(3);
            end else if (done_go) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         ph_ff        <= '0;
         trep_ff      <= 1'b0;
         prep_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         th0_ff       <= '0;
         th1_ff       <= '0;
         ph0_ff       <= '0;
         ph1_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         ph_ff        <= ph_in;
         trep_ff      <= trep_in;
         prep_ff      <= prep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (done_go) begin
            th1_ff <= th0_ff;
            th0_ff <= t_ff;
            ph1_ff <= ph0_ff;
            ph0_ff <= p_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         traw_ff <= req_tdata[23:0];
         praw_ff <= req_tdata[47:24];
      end
      if (wr_en) begin
         if (cur.dst == RAM_AW'(R_T)) begin
            t_ff <= fpu_res;
         end
         if (cur.dst == RAM_AW'(R_P)) begin
            p_ff <= fpu_res;
         end
         if (cur.dst == RAM_AW'(R_DPOS)) begin
            dpos_ff <= fpu_res;
         end
         if (cur.dst == RAM_AW'(R_DNEG)) begin
            dneg_ff <= fpu_res;
         end
      end
      if (done_go) begin
         rsp_data_ff <= {t_ff, p_ff};
         rsp_user_ff <= {prep_ff, trep_ff};
      end
   end

endmodule

// ===== hdl/bce_ram.sv =====
module bce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   output logic [WIDTH-1:0]         rdata_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a <= mem_ff[raddr_a];
      rdata_b <= mem_ff[raddr_b];
   end

endmodule

// ===== hdl/bce_fpu.sv =====
module bce_fpu (
   input  logic                       clock,
   input  bce_pkg::fpu_req_type       req,
   output logic [bce_pkg::FLT_W-1:0]  result
);

   import bce_pkg::*;

   localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
   localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

   // stage a: unpack, align and add, multiply, or take an integer to convert
   logic              sa, sb, sbe, nan_a, nan_b, inf_a, inf_b;
   logic [7:0]        ea_f, eb_f;
   logic [23:0]       ma, mb, mbig, msml;
   logic signed [10:0] xa, xb, xbig, xsml, dexp;
   logic [4:0]        dsh;
   logic [26:0]       mb3, ms3, ms_sh;
   logic              lost3, a_big, sbig;
   logic [27:0]       sum28;
   logic [24:0]       cvt_mag;
   logic              s_in, spec_in;
   logic signed [10:0] e_in;
   logic [47:0]       m_in;
   logic [31:0]       spec_val_in;

   logic              s_a_ff, spec_a_ff;
   logic signed [10:0] e_a_ff;
   logic [47:0]       m_a_ff;
   logic [31:0]       spec_val_a_ff;

   always_comb begin
      sa    = req.a[31];
      sb    = req.b[31];
      ea_f  = req.a[30:23];
      eb_f  = req.b[30:23];
      nan_a = (ea_f == 8'hFF) && (req.a[22:0] != '0);
      nan_b = (eb_f == 8'hFF) && (req.b[22:0] != '0);
      inf_a = (ea_f == 8'hFF) && (req.a[22:0] == '0);
      inf_b = (eb_f == 8'hFF) && (req.b[22:0] == '0);
      ma    = {ea_f != 8'd0, req.a[22:0]};
      mb    = {eb_f != 8'd0, req.b[22:0]};
      xa    = (ea_f == 8'd0) ? -11'sd149 : $signed({3'b000, ea_f}) - 11'sd150;
      xb    = (eb_f == 8'd0) ? -11'sd149 : $signed({3'b000, eb_f}) - 11'sd150;
      sbe   = (req.op == OP_SUB) ? ~sb : sb;

      a_big = (xa > xb) || ((xa == xb) && (ma >= mb));
      mbig  = a_big ? ma : mb;
      msml  = a_big ? mb : ma;
      xbig  = a_big ? xa : xb;
      xsml  = a_big ? xb : xa;
      sbig  = a_big ? sa : sbe;
      dexp  = xbig - xsml;
      dsh   = (dexp > 11'sd27) ? 5'd27 : dexp[4:0];
      mb3   = {mbig, 3'b000};
      ms3   = {msml, 3'b000};
      ms_sh = ms3 >> dsh;
      lost3 = |(ms3 & ((27'd1 << dsh) - 27'd1));
      if (sa != sbe) begin
         sum28 = {1'b0, mb3} - {1'b0, ms_sh[26:1], ms_sh[0] | lost3};
      end else begin
         sum28 = {1'b0, mb3} + {1'b0, ms_sh[26:1], ms_sh[0] | lost3};
      end

      cvt_mag = req.cvt_int[CVT_W-1] ? 25'(-req.cvt_int) : 25'(req.cvt_int);

      spec_in     = 1'b0;
      spec_val_in = '0;
      s_in        = 1'b0;
      e_in        = '0;
      m_in        = '0;
      unique case (req.op)
         OP_MUL: begin
            s_in = sa ^ sb;
            e_in = xa + xb;
            m_in = ma * mb;
            if (nan_a || nan_b) begin
               spec_in     = 1'b1;
               spec_val_in = nan_a ? (req.a | QUIET_BIT) : (req.b | QUIET_BIT);
            end else if ((inf_a && (req.b[30:0] == '0)) ||
                         (inf_b && (req.a[30:0] == '0))) begin
               spec_in     = 1'b1;
               spec_val_in = DEFAULT_NAN;
            end else if (inf_a || inf_b) begin
               spec_in     = 1'b1;
               spec_val_in = {sa ^ sb, 8'hFF, 23'd0};
            end
         end
         OP_ADD, OP_SUB: begin
            s_in = (sum28 == '0) ? (sa & sbe) : sbig;
            e_in = xbig - 11'sd3;
            m_in = {20'd0, sum28};
            if (nan_a || nan_b) begin
               spec_in     = 1'b1;
               spec_val_in = nan_a ? (req.a | QUIET_BIT) : (req.b | QUIET_BIT);
            end else if (inf_a && inf_b && (sa != sbe)) begin
               spec_in     = 1'b1;
               spec_val_in = DEFAULT_NAN;
            end else if (inf_a) begin
               spec_in     = 1'b1;
               spec_val_in = req.a;
            end else if (inf_b) begin
               spec_in     = 1'b1;
               spec_val_in = {sbe, 8'hFF, 23'd0};
            end
         end
         OP_CVT: begin
            s_in = req.cvt_int[CVT_W-1];
            e_in = 11'(req.scale);
            m_in = {23'd0, cvt_mag};
         end
         default: begin
            s_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s_a_ff        <= s_in;
      e_a_ff        <= e_in;
      m_a_ff        <= m_in;
      spec_a_ff     <= spec_in;
      spec_val_a_ff <= spec_val_in;
   end

   // stage b: leading zero count and normalize
   logic [5:0]         lz;
   logic               s_b_ff, spec_b_ff, zero_b_ff;
   logic signed [10:0] eb_b_ff;
   logic [47:0]        m_b_ff;
   logic [31:0]        spec_val_b_ff;

   always_comb begin
      lz = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (m_a_ff[i]) begin
            lz = 6'(47 - i);
         end
      end
   end

   always_ff @(posedge clock) begin
      s_b_ff        <= s_a_ff;
      spec_b_ff     <= spec_a_ff;
      spec_val_b_ff <= spec_val_a_ff;
      zero_b_ff     <= (m_a_ff == '0);
      m_b_ff        <= m_a_ff << lz;
      // biased exponent of the leading one
      eb_b_ff       <= e_a_ff + 11'sd174 - $signed({5'd0, lz});
   end

   // stage c: denormalize, round to nearest even, pack
   logic [5:0]         dn_sh;
   logic signed [10:0] dn_amt, eb_x, eb_r;
   logic [47:0]        m_dn;
   logic               dn_lost, rbit, sbit, inc;
   logic [23:0]        mant;
   logic [24:0]        m25;
   logic [22:0]        frac;
   logic [31:0]        packed_val;

   always_comb begin
      dn_amt  = 11'sd1 - eb_b_ff;
      if (eb_b_ff >= 11'sd1) begin
         dn_sh = 6'd0;
      end else if (dn_amt > 11'sd49) begin
         dn_sh = 6'd49;
      end else begin
         dn_sh = dn_amt[5:0];
      end
      m_dn    = m_b_ff >> dn_sh;
      dn_lost = |(m_b_ff & ((48'd1 << dn_sh) - 48'd1));
      mant    = m_dn[47:24];
      rbit    = m_dn[23];
      sbit    = (|m_dn[22:0]) | dn_lost;
      inc     = rbit & (sbit | mant[0]);
      m25     = {1'b0, mant} + {24'd0, inc};
      eb_x    = (eb_b_ff >= 11'sd1) ? eb_b_ff : 11'sd0;
      if (m25[24]) begin
         eb_r = eb_x + 11'sd1;
         frac = 23'd0;
      end else begin
         eb_r = ((eb_x == 11'sd0) && m25[23]) ? 11'sd1 : eb_x;
         frac = m25[22:0];
      end
      if (spec_b_ff) begin
         packed_val = spec_val_b_ff;
      end else if (zero_b_ff) begin
         packed_val = {s_b_ff, 31'd0};
      end else if (eb_r >= 11'sd255) begin
         packed_val = {s_b_ff, 8'hFF, 23'd0};
      end else begin
         packed_val = {s_b_ff, eb_r[7:0], frac};
      end
   end

   always_ff @(posedge clock) begin
      result <= packed_val;
   end

endmodule
